// ----- src/neighbor_bearing_table_core_defines.svh -----
// assertion macros shared by the neighbor bearing table rtl
// no dependencies; included by the files that carry assertions
`ifndef NEIGHBOR_BEARING_TABLE_CORE_DEFINES_SVH
`define NEIGHBOR_BEARING_TABLE_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define NBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define NBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/nbt_pkg.sv -----
// shared types, codes and the cosine table of the neighbor bearing table
// no dependencies
package nbt_pkg;

    localparam logic [1:0] CMD_DIRECT = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_TX     = 2'd2;

    localparam logic [1:0] KIND_ANGLE = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic CFG_OWN_ID   = 1'b0;
    localparam logic CFG_BASELINE = 1'b1;

    localparam logic [7:0] BASELINE_RST = 8'd38;
    localparam logic [7:0] BEARING_MAX  = 8'd180;
    localparam int         ENTRY_W      = 2;

    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    // (2n-1)(2n) for the taylor terms n = 1..8
    localparam longint TAYLOR_DIV [8] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56,
                                          64'sd90, 64'sd132, 64'sd182, 64'sd240};

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] own_d;
        logic [7:0] partner_d;
        logic [7:0] bearing;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_tx;
        logic       take_hit;
        logic       take_new;
        logic       b_start;
        logic       wr;
        logic       emit;
        logic [1:0] kind;
        logic       last;
        logic       entry_inc;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic       in_acc;
        logic [1:0] cmd;
        logic       direct_ok;
        logic       report_ok;
        logic       count_zero;
        logic       idx_end;
        logic       full;
        logic       hit;
        logic       both_nz;
        logic       b_done;
        logic       out_free;
        logic       last_entry;
    } t_sts;

    typedef logic signed [17:0] t_cos_tab [0:180];

    // taylor series in q30, rounded to q16
    function automatic longint cos_quadrant(input int k);
        longint x;
        longint term;
        longint sum;
        int     n;
        x    = (longint'(k) * PI_Q30) / 180;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (n = 0; n < 8; n++) begin
            term = term * x / ONE_Q30;
            term = term * x / ONE_Q30;
            term = -(term / TAYLOR_DIV[n]);
            sum  = sum + term;
        end
        return (sum + 8192) / 16384;
    endfunction

    function automatic t_cos_tab cos_table();
        t_cos_tab t;
        int       k;
        for (k = 0; k <= 180; k++) begin
            if (k <= 90) begin
                t[k] = 18'(cos_quadrant(k));
            end else begin
                t[k] = 18'(-cos_quadrant(180 - k));
            end
        end
        return t;
    endfunction

    localparam t_cos_tab COS_TAB = cos_table();

endpackage

// ----- src/nbt_bearing.sv -----
// multi-cycle bearing unit: squares, iterative square root, iterative divide
// and a bitwise search of the cosine table; depends on nbt_pkg
module nbt_bearing (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_d_own,
    input  logic [7:0] i_d_partner,
    input  logic       i_own_odd,
    input  logic [7:0] i_d0,
    output logic       o_done,
    output logic [7:0] o_bearing
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_SQ   = 4'd1;
    localparam logic [3:0] B_X4   = 4'd2;
    localparam logic [3:0] B_SQRT = 4'd3;
    localparam logic [3:0] B_MUL  = 4'd4;
    localparam logic [3:0] B_DIV  = 4'd5;
    localparam logic [3:0] B_SAT  = 4'd6;
    localparam logic [3:0] B_SRCH = 4'd7;
    localparam logic [3:0] B_DONE = 4'd8;

    logic [3:0]         r_state;
    logic [7:0]         r_d0, r_d1, r_d2;
    logic [15:0]        r_sq0, r_sq1, r_sq2, r_p10;
    logic [19:0]        r_x4;
    logic [35:0]        r_v;
    logic [20:0]        r_rem;
    logic [17:0]        r_root;
    logic [5:0]         r_cnt;
    logic [26:0]        r_dd;
    logic               r_neg;
    logic [43:0]        r_q;
    logic [27:0]        r_drem;
    logic signed [17:0] r_c;
    logic [7:0]         r_best;
    logic [7:0]         r_bit;

    logic signed [21:0] s_num, s_den, s_x4, s_m;
    logic [19:0]        x4_clamp;
    logic [20:0]        rem_sh;
    logic [19:0]        trial;
    logic               sq_ge;
    logic [27:0]        drem_sh;
    logic               dv_ge;
    logic [21:0]        m_mag;
    logic [16:0]        c_mag;
    logic [7:0]         srch_k;
    logic [7:0]         srch_idx;
    logic               srch_ok;

    always_comb begin
        s_num = $signed({6'd0, r_sq1}) + $signed({6'd0, r_sq0}) - $signed({6'd0, r_sq2});
        s_den = $signed({5'd0, r_p10, 1'b0});
        if (s_den == 22'sd0) begin
            s_x4 = $signed({6'd0, r_sq0}) + $signed({4'd0, r_sq1, 2'b00});
        end else if (s_num >= s_den) begin
            s_x4 = $signed({4'd0, r_sq1, 2'b00}) - $signed({4'd0, r_p10, 2'b00})
                 + $signed({6'd0, r_sq0});
        end else if (s_num <= -s_den) begin
            s_x4 = $signed({4'd0, r_sq1, 2'b00}) + $signed({4'd0, r_p10, 2'b00})
                 + $signed({6'd0, r_sq0});
        end else begin
            s_x4 = $signed({5'd0, r_sq1, 1'b0}) + $signed({5'd0, r_sq2, 1'b0})
                 - $signed({6'd0, r_sq0});
        end
        x4_clamp = (s_x4 < 22'sd0) ? 20'd0 : s_x4[19:0];

        rem_sh = {r_rem[18:0], r_v[35:34]};
        trial  = {r_root, 2'b01};
        sq_ge  = (rem_sh >= {1'b0, trial});

        s_m   = $signed({2'd0, r_x4}) + $signed({6'd0, r_sq0}) - $signed({4'd0, r_sq2, 2'b00});
        m_mag = (s_m < 22'sd0) ? 22'(-s_m) : 22'(s_m);

        drem_sh = {r_drem[26:0], r_q[43]};
        dv_ge   = (drem_sh >= {1'b0, r_dd});

        c_mag = (r_q > 44'd65536) ? 17'd65536 : r_q[16:0];

        srch_k   = r_best | r_bit;
        srch_idx = (srch_k <= nbt_pkg::BEARING_MAX) ? srch_k : nbt_pkg::BEARING_MAX;
        srch_ok  = (srch_k <= nbt_pkg::BEARING_MAX) && (r_c <= nbt_pkg::COS_TAB[srch_idx]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: if (i_start) r_state <= B_SQ;
                B_SQ:   r_state <= B_X4;
                B_X4:   r_state <= B_SQRT;
                B_SQRT: if (r_cnt == 6'd0) r_state <= B_MUL;
                B_MUL:  r_state <= B_DIV;
                B_DIV: begin
                    if (r_dd == 27'd0) begin
                        r_state <= B_SRCH;
                    end else if (r_cnt == 6'd0) begin
                        r_state <= B_SAT;
                    end
                end
                B_SAT:  r_state <= B_SRCH;
                B_SRCH: if (r_bit == 8'd1) r_state <= B_DONE;
                B_DONE: r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_d0 <= i_d0;
                r_d1 <= i_own_odd ? i_d_partner : i_d_own;
                r_d2 <= i_own_odd ? i_d_own : i_d_partner;
            end
            B_SQ: begin
                r_sq0 <= r_d0 * r_d0;
                r_sq1 <= r_d1 * r_d1;
                r_sq2 <= r_d2 * r_d2;
                r_p10 <= r_d1 * r_d0;
            end
            B_X4: begin
                r_x4   <= x4_clamp;
                r_v    <= {x4_clamp, 16'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd17;
            end
            B_SQRT: begin
                r_v    <= {r_v[33:0], 2'b00};
                r_rem  <= sq_ge ? (rem_sh - {1'b0, trial}) : rem_sh;
                r_root <= {r_root[16:0], sq_ge};
                r_cnt  <= r_cnt - 6'd1;
            end
            B_MUL: begin
                r_dd   <= {26'(r_d0) * 26'(r_root), 1'b0};
                r_neg  <= (s_m < 22'sd0);
                r_q    <= {m_mag[19:0], 24'd0};
                r_drem <= '0;
                r_cnt  <= 6'd43;
            end
            B_DIV: begin
                if (r_dd == 27'd0) begin
                    r_c    <= '0;
                    r_best <= '0;
                    r_bit  <= 8'h80;
                end else begin
                    r_drem <= dv_ge ? (drem_sh - {1'b0, r_dd}) : drem_sh;
                    r_q    <= {r_q[42:0], dv_ge};
                    r_cnt  <= r_cnt - 6'd1;
                end
            end
            B_SAT: begin
                r_c    <= r_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
                r_best <= '0;
                r_bit  <= 8'h80;
            end
            B_SRCH: begin
                if (srch_ok) r_best <= srch_k;
                r_bit <= r_bit >> 1;
            end
            default: ;
        endcase
    end

    assign o_done    = (r_state == B_DONE);
    assign o_bearing = r_best;

endmodule

// ----- src/nbt_datapath.sv -----
// table memory, item registers, output register and bearing unit
// depends on nbt_pkg, nbt_bearing and the assertion macro header
`include "neighbor_bearing_table_core_defines.svh"

module nbt_datapath #(
    parameter int TABLE_DEPTH    = 16,
    parameter int REPORT_ENTRIES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nbt_pkg::t_ctl      i_ctl,
    output nbt_pkg::t_sts      o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_sender_id,
    input  logic [7:0]         i_measured_distance,
    input  logic               i_report_nonempty,
    input  logic [3*8-1:0]     i_entry_id,
    input  logic [3*8-1:0]     i_entry_distance,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_node_id,
    output logic [7:0]         o_distance_out,
    output logic [7:0]         o_bearing_deg,
    output logic               o_bearing_valid,
    output logic               o_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    nbt_pkg::t_entry r_mem [TABLE_DEPTH];
    nbt_pkg::t_entry r_rdata;
    nbt_pkg::t_entry r_word;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [nbt_pkg::ENTRY_W-1:0] r_entry;
    logic            r_bvalid;
    logic [7:0]      r_own_id, r_baseline;
    logic [1:0]      r_cmd;
    logic [7:0]      r_sender, r_dist;
    logic            r_nonempty;
    logic [7:0]      r_eid   [3];
    logic [7:0]      r_edist [3];

    logic            r_ovalid, r_olast, r_ovld_b;
    logic [1:0]      r_okind;
    logic [7:0]      r_oid, r_odist, r_obear;

    logic [7:0]      cur_id, cur_dist, partner;
    logic [CW-1:0]   entry_ext, tx_idx;
    logic            load, out_free;
    nbt_pkg::t_entry base;
    logic            b_done;
    logic [7:0]      b_bearing;

    nbt_bearing u_bearing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_ctl.b_start),
        .i_d_own     (r_word.own_d),
        .i_d_partner (r_word.partner_d),
        .i_own_odd   (r_own_id[0]),
        .i_d0        (r_baseline),
        .o_done      (b_done),
        .o_bearing   (b_bearing)
    );

    always_comb begin
        partner   = r_own_id ^ 8'd1;
        load      = i_ctl.in_ready & i_in_valid;
        out_free  = !r_ovalid || i_out_ready;
        entry_ext = CW'(r_entry);
        tx_idx    = (entry_ext < r_count) ? (r_count - CW'(1) - entry_ext) : '0;
        case (r_entry)
            2'd1:    begin cur_id = r_eid[1]; cur_dist = r_edist[1]; end
            2'd2:    begin cur_id = r_eid[2]; cur_dist = r_edist[2]; end
            default: begin cur_id = r_eid[0]; cur_dist = r_edist[0]; end
        endcase
        if (r_cmd == nbt_pkg::CMD_DIRECT) begin
            cur_id   = r_sender;
            cur_dist = r_dist;
        end
        base = i_ctl.take_hit ? r_rdata : {cur_id, 8'd0, 8'd0, 8'd0};
        if (r_cmd == nbt_pkg::CMD_DIRECT) begin
            base.own_d = cur_dist;
        end else begin
            base.partner_d = cur_dist;
        end
    end

    always_comb begin
        o_sts.in_acc     = load;
        o_sts.cmd        = r_cmd;
        o_sts.direct_ok  = (r_sender != r_own_id) && (r_sender != partner);
        o_sts.report_ok  = (r_sender == partner) && r_nonempty;
        o_sts.count_zero = (r_count == '0);
        o_sts.idx_end    = (r_idx == r_count);
        o_sts.full       = (r_count == CW'(TABLE_DEPTH));
        o_sts.hit        = (r_rdata.id == cur_id);
        o_sts.both_nz    = (r_word.own_d != 8'd0) && (r_word.partner_d != 8'd0);
        o_sts.b_done     = b_done;
        o_sts.out_free   = out_free;
        o_sts.last_entry = (r_entry == nbt_pkg::ENTRY_W'(REPORT_ENTRIES - 1));
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) r_mem[r_idx[IW-1:0]] <= r_word;
        r_rdata <= r_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_own_id   <= 8'd0;
            r_baseline <= nbt_pkg::BASELINE_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == nbt_pkg::CFG_OWN_ID) r_own_id <= i_cfg_data;
                else r_baseline <= i_cfg_data;
            end
            if (i_ctl.take_new) r_count <= r_count + CW'(1);
            if (i_ctl.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd      <= i_command;
            r_sender   <= i_sender_id;
            r_dist     <= i_measured_distance;
            r_nonempty <= i_report_nonempty;
            for (int e = 0; e < 3; e++) begin
                r_eid[e]   <= i_entry_id[e*8 +: 8];
                r_edist[e] <= i_entry_distance[e*8 +: 8];
            end
            r_entry <= '0;
        end else if (i_ctl.entry_inc) begin
            r_entry <= r_entry + nbt_pkg::ENTRY_W'(1);
        end

        if (i_ctl.idx_clr) r_idx <= '0;
        else if (i_ctl.idx_inc) r_idx <= r_idx + CW'(1);
        else if (i_ctl.idx_tx) r_idx <= tx_idx;

        if (i_ctl.take_hit || i_ctl.take_new) begin
            r_word   <= base;
            r_bvalid <= 1'b0;
        end else if (b_done) begin
            r_word.bearing <= b_bearing;
            r_bvalid       <= 1'b1;
        end

        if (i_ctl.emit) begin
            r_okind <= i_ctl.kind;
            r_olast <= i_ctl.last;
            case (i_ctl.kind)
                nbt_pkg::KIND_ANGLE: begin
                    r_oid <= r_word.id;  r_odist <= r_word.own_d;
                    r_obear <= r_word.bearing;  r_ovld_b <= r_bvalid;
                end
                nbt_pkg::KIND_ENTRY: begin
                    r_oid <= r_rdata.id;  r_odist <= r_rdata.own_d;
                    r_obear <= r_rdata.bearing;  r_ovld_b <= 1'b0;
                end
                nbt_pkg::KIND_DROP: begin
                    r_oid <= cur_id;  r_odist <= 8'd0;
                    r_obear <= 8'd0;  r_ovld_b <= 1'b0;
                end
                default: begin
                    r_oid <= 8'd0;  r_odist <= 8'd0;
                    r_obear <= 8'd0;  r_ovld_b <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_kind          = r_okind;
    assign o_node_id       = r_oid;
    assign o_distance_out  = r_odist;
    assign o_bearing_deg   = r_obear;
    assign o_bearing_valid = r_ovld_b;
    assign o_last          = r_olast;

    `NBT_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, i_ctl.take_new, r_count == CW'($past(r_count) + CW'(1)))
    `NBT_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, i_ctl.emit, out_free)
    `NBT_ASSERT_SAME(a_bearing_range, i_clk, i_rst_n, b_done, b_bearing <= nbt_pkg::BEARING_MAX)
    `NBT_ASSERT_SAME(a_write_inside, i_clk, i_rst_n, i_ctl.wr, r_idx < r_count)

endmodule

// ----- src/nbt_ctrl.sv -----
// controller state machine of the neighbor bearing table
// depends on nbt_pkg; drives the datapath through t_ctl, reads t_sts
module nbt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nbt_pkg::t_sts i_sts,
    output nbt_pkg::t_ctl o_ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SRD      = 4'd2;
    localparam logic [3:0] S_SCMP     = 4'd3;
    localparam logic [3:0] S_APPLY    = 4'd4;
    localparam logic [3:0] S_BWAIT    = 4'd5;
    localparam logic [3:0] S_WRITE    = 4'd6;
    localparam logic [3:0] S_EMIT_UPD = 4'd7;
    localparam logic [3:0] S_DROP     = 4'd8;
    localparam logic [3:0] S_TX_ADDR  = 4'd9;
    localparam logic [3:0] S_TX_RD    = 4'd10;
    localparam logic [3:0] S_TX_EMIT  = 4'd11;
    localparam logic [3:0] S_EMPTY    = 4'd12;

    logic [3:0] r_state, n_state;
    logic       upd_last;

    always_comb begin
        o_ctl    = '0;
        n_state  = r_state;
        upd_last = (i_sts.cmd == nbt_pkg::CMD_DIRECT) || i_sts.last_entry;
        case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_sts.in_acc) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_ctl.idx_clr = 1'b1;
                case (i_sts.cmd)
                    nbt_pkg::CMD_DIRECT: n_state = i_sts.direct_ok ? S_SRD : S_IDLE;
                    nbt_pkg::CMD_REPORT: n_state = i_sts.report_ok ? S_SRD : S_IDLE;
                    nbt_pkg::CMD_TX:     n_state = i_sts.count_zero ? S_EMPTY : S_TX_ADDR;
                    default:             n_state = S_IDLE;
                endcase
            end
            S_SRD: begin
                if (!i_sts.idx_end) begin
                    n_state = S_SCMP;
                end else if (i_sts.full) begin
                    n_state = S_DROP;
                end else begin
                    o_ctl.take_new = 1'b1;
                    n_state        = S_APPLY;
                end
            end
            S_SCMP: begin
                if (i_sts.hit) begin
                    o_ctl.take_hit = 1'b1;
                    n_state        = S_APPLY;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_APPLY: begin
                if (i_sts.both_nz) begin
                    o_ctl.b_start = 1'b1;
                    n_state       = S_BWAIT;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_BWAIT: if (i_sts.b_done) n_state = S_WRITE;
            S_WRITE: begin
                o_ctl.wr = 1'b1;
                n_state  = S_EMIT_UPD;
            end
            S_EMIT_UPD, S_DROP: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = (r_state == S_DROP) ? nbt_pkg::KIND_DROP : nbt_pkg::KIND_ANGLE;
                    o_ctl.last = upd_last;
                    if (upd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.entry_inc = 1'b1;
                        o_ctl.idx_clr   = 1'b1;
                        n_state         = S_SRD;
                    end
                end
            end
            S_TX_ADDR: begin
                o_ctl.idx_tx = 1'b1;
                n_state      = S_TX_RD;
            end
            S_TX_RD: n_state = S_TX_EMIT;
            S_TX_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = nbt_pkg::KIND_ENTRY;
                    o_ctl.last = i_sts.last_entry;
                    if (i_sts.last_entry) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.entry_inc = 1'b1;
                        n_state         = S_TX_ADDR;
                    end
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = nbt_pkg::KIND_EMPTY;
                    o_ctl.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/neighbor_bearing_table_core.sv -----
// top level of the neighbor bearing table: stream ports and config port
// depends on nbt_pkg, nbt_ctrl and nbt_datapath
//
// usage
// - slave stream carries one command per transaction: direct reception,
//   partner report or transmit request (tuser holds the command)
// - master stream returns result transactions; tlast marks the last one
//   of an item; tuser holds the result kind
// - config writes (own id, baseline) are taken on any cycle with i_cfg_we
// - an item is handled alone: the table search reads one entry at a time
//   from the single-port table memory, through a read state and a
//   compare state for each entry
// - a bearing update runs through the bearing unit (18-step
//   square root, 44-step divide, 8-step cosine table search)
// - a transmit request has address, read and emit states per result
// - results sit in an output register; a stalled receiver holds the
//   controller at its next result, and a new item is taken while the
//   final result of the previous one still waits
// - reset empties the table at once (fill count) and restores baseline 38
module neighbor_bearing_table_core #(
    parameter int TABLE_DEPTH    = 16,
    parameter int REPORT_ENTRIES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sender_id, measured_distance, report_nonempty, entry0_id,
    // entry0_distance, entry1_id, entry1_distance, entry2_id, entry2_distance
    input  logic [71:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // node_id, distance_out, bearing_deg, bearing_valid
    output logic [31:0] m_axis_tdata,
    // kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    nbt_pkg::t_ctl ctl;
    nbt_pkg::t_sts sts;
    logic [7:0]    node_id, distance_out, bearing_deg;
    logic          bearing_valid;

    nbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    nbt_datapath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .REPORT_ENTRIES (REPORT_ENTRIES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (ctl),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (s_axis_tvalid),
        .i_command           (s_axis_tuser),
        .i_sender_id         (s_axis_tdata[7:0]),
        .i_measured_distance (s_axis_tdata[15:8]),
        .i_report_nonempty   (s_axis_tdata[16]),
        .i_entry_id          ({s_axis_tdata[56:49], s_axis_tdata[40:33], s_axis_tdata[24:17]}),
        .i_entry_distance    ({s_axis_tdata[64:57], s_axis_tdata[48:41], s_axis_tdata[32:25]}),
        .i_out_ready         (m_axis_tready),
        .o_out_valid         (m_axis_tvalid),
        .o_kind              (m_axis_tuser),
        .o_node_id           (node_id),
        .o_distance_out      (distance_out),
        .o_bearing_deg       (bearing_deg),
        .o_bearing_valid     (bearing_valid),
        .o_last              (m_axis_tlast)
    );

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tdata  = {7'd0, bearing_valid, bearing_deg, distance_out, node_id};

endmodule
